### hdl/murmur3_seed_rotator_defines.svh
// assertion macros for the murmur3 seed rotator
// expects i_clk and i_rst_n in the module that uses them
`ifndef MURMUR3_SEED_ROTATOR_DEFINES_SVH
`define MURMUR3_SEED_ROTATOR_DEFINES_SVH

// consequent checked in the same cycle
`define MM3SR_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the next cycle
`define MM3SR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/mm3sr_pkg.sv
// shared types, constants and microcode rom for the murmur3 seed rotator
// no dependencies
package mm3sr_pkg;

    localparam int SEED_BYTES = 32;
    localparam int SEED_WORDS = SEED_BYTES / 4;
    localparam int WORD_AW    = $clog2(SEED_WORDS);
    localparam int STEP_W     = 4;

    localparam logic [31:0] C_C1    = 32'hCC9E2D51;
    localparam logic [31:0] C_C2    = 32'h1B873593;
    localparam logic [31:0] C_N     = 32'hE6546B64;
    localparam logic [31:0] C_F1    = 32'h85EBCA6B;
    localparam logic [31:0] C_F2    = 32'hC2B2AE35;
    localparam logic [31:0] C_RUN0  = 32'h5BD1E995;
    localparam logic [31:0] C_LEN   = 32'(SEED_BYTES);

    localparam logic [WORD_AW-1:0] PASS_LAST = WORD_AW'(SEED_WORDS - 1);

    // hash register operations
    localparam logic [2:0] H_NOP  = 3'd0;
    localparam logic [2:0] H_INIT = 3'd1;
    localparam logic [2:0] H_MIX  = 3'd2;
    localparam logic [2:0] H_FIN1 = 3'd3;
    localparam logic [2:0] H_FIN2 = 3'd4;
    localparam logic [2:0] H_FIN3 = 3'd5;

    // sequencer flow codes
    localparam logic [1:0] JMP_NEXT = 2'd0;
    localparam logic [1:0] JMP_LOOP = 2'd1;
    localparam logic [1:0] JMP_EMIT = 2'd2;

    localparam logic [STEP_W-1:0] STEP_FIRST = 4'd0;
    localparam logic [STEP_W-1:0] STEP_LOOP  = 4'd12;
    localparam logic [STEP_W-1:0] STEP_EMIT  = 4'd13;

    // request kinds
    localparam logic REQ_RESTART = 1'b0;
    localparam logic REQ_DERIVE  = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [31:0] block_index;
    } t_req;

    typedef struct packed {
        logic [63:0] seed_part_3;
        logic [63:0] seed_part_2;
        logic [63:0] seed_part_1;
        logic [63:0] seed_part_0;
    } t_res;

    typedef logic [3:0][63:0] t_master;

    typedef struct packed {
        logic               k1_en;
        logic [WORD_AW-1:0] k1_addr;
        logic               k2_en;
        logic [2:0]         h_op;
        logic [1:0]         jmp;
        logic [STEP_W-1:0]  target;
    } t_uword;

    typedef struct packed {
        logic               k1_en;
        logic [WORD_AW-1:0] k1_addr;
        logic               k2_en;
        logic [2:0]         h_op;
        logic [WORD_AW-1:0] pass;
        logic               emit;
    } t_ctl;

    // one pass: block mixes overlapped three deep, then the finalizer
    function automatic t_uword ucode_rom(input logic [STEP_W-1:0] step);
        t_uword w;
        w        = '0;
        w.jmp    = JMP_NEXT;
        w.h_op   = H_NOP;
        unique case (step)
            4'd0: begin
                w.k1_en  = 1'b1;
                w.k1_addr = '0;
                w.h_op   = H_INIT;
            end
            4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7: begin
                w.k1_en   = 1'b1;
                w.k1_addr = step[WORD_AW-1:0];
                w.k2_en   = 1'b1;
                w.h_op    = (step == 4'd1) ? H_NOP : H_MIX;
            end
            4'd8: begin
                w.k2_en = 1'b1;
                w.h_op  = H_MIX;
            end
            4'd9:  w.h_op = H_MIX;
            4'd10: w.h_op = H_FIN1;
            4'd11: w.h_op = H_FIN2;
            4'd12: begin
                w.h_op   = H_FIN3;
                w.jmp    = JMP_LOOP;
                w.target = STEP_FIRST;
            end
            default: w.jmp = JMP_EMIT;
        endcase
        return w;
    endfunction

endpackage

### hdl/mm3sr_useq.sv
// microcode sequencer: step counter, pass counter, rom and flow control
// depends on mm3sr_pkg and murmur3_seed_rotator_defines.svh
`include "murmur3_seed_rotator_defines.svh"

module mm3sr_useq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_derive,
    input  logic             i_out_free,
    output logic             o_busy,
    output mm3sr_pkg::t_ctl  o_ctl
);

    logic                                 r_busy, n_busy;
    logic [mm3sr_pkg::STEP_W-1:0]         r_step, n_step;
    logic [mm3sr_pkg::WORD_AW-1:0]        r_pass, n_pass;
    mm3sr_pkg::t_uword                    uw;
    logic                                 emit;

    assign uw = mm3sr_pkg::ucode_rom(r_step);

    always_comb begin
        n_busy = r_busy;
        n_step = r_step;
        n_pass = r_pass;
        emit   = 1'b0;
        if (!r_busy) begin
            if (i_start) begin
                n_busy = 1'b1;
                n_pass = '0;
                n_step = i_derive ? mm3sr_pkg::STEP_FIRST : mm3sr_pkg::STEP_EMIT;
            end
        end else begin
            unique case (uw.jmp)
                mm3sr_pkg::JMP_NEXT: n_step = r_step + 1'b1;
                mm3sr_pkg::JMP_LOOP: begin
                    if (r_pass != mm3sr_pkg::PASS_LAST) begin
                        n_step = uw.target;
                        n_pass = r_pass + 1'b1;
                    end else begin
                        n_step = r_step + 1'b1;
                    end
                end
                mm3sr_pkg::JMP_EMIT: begin
                    if (i_out_free) begin
                        emit   = 1'b1;
                        n_busy = 1'b0;
                    end
                end
                default: n_step = mm3sr_pkg::STEP_EMIT;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= mm3sr_pkg::STEP_FIRST;
            r_pass <= '0;
        end else begin
            r_busy <= n_busy;
            r_step <= n_step;
            r_pass <= n_pass;
        end
    end

    always_comb begin
        o_ctl.k1_en   = r_busy & uw.k1_en;
        o_ctl.k1_addr = uw.k1_addr;
        o_ctl.k2_en   = r_busy & uw.k2_en;
        o_ctl.h_op    = r_busy ? uw.h_op : mm3sr_pkg::H_NOP;
        o_ctl.pass    = r_pass;
        o_ctl.emit    = emit;
    end

    assign o_busy = r_busy;

    // last pass falls through to the emit step
    `MM3SR_ASSERT_NEXT(a_last_pass_emit, r_busy && r_step == mm3sr_pkg::STEP_LOOP && r_pass == mm3sr_pkg::PASS_LAST, r_step == mm3sr_pkg::STEP_EMIT, "last pass did not reach emit")
    // emit ends the item
    `MM3SR_ASSERT_NEXT(a_emit_idle, emit, !r_busy, "sequencer still busy after emit")

endmodule

### hdl/mm3sr_dpath.sv
// datapath: seed words, block mix registers, hash and running hash
// depends on mm3sr_pkg
module mm3sr_dpath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_ld_master,
    input  logic               i_ld_derive,
    input  logic [31:0]        i_block_index,
    input  mm3sr_pkg::t_master i_master,
    input  mm3sr_pkg::t_ctl    i_ctl,
    output mm3sr_pkg::t_res    o_seed
);

    logic [31:0] r_seed [mm3sr_pkg::SEED_WORDS];
    logic [31:0] r_k1;
    logic [31:0] r_k2;
    logic [31:0] r_h, n_h;
    logic [31:0] r_run;
    logic [31:0] mix_t, fin_t, rot_k1;

    assign rot_k1 = {r_k1[16:0], r_k1[31:17]};

    always_comb begin
        mix_t = r_h ^ r_k2;
        mix_t = {mix_t[18:0], mix_t[31:19]};
        fin_t = '0;
        n_h   = r_h;
        unique case (i_ctl.h_op)
            mm3sr_pkg::H_INIT: n_h = r_run ^ {{(32 - mm3sr_pkg::WORD_AW){1'b0}}, i_ctl.pass};
            mm3sr_pkg::H_MIX:  n_h = (mix_t << 2) + mix_t + mm3sr_pkg::C_N;
            mm3sr_pkg::H_FIN1: begin
                fin_t = r_h ^ mm3sr_pkg::C_LEN;
                fin_t = fin_t ^ (fin_t >> 16);
                n_h   = fin_t * mm3sr_pkg::C_F1;
            end
            mm3sr_pkg::H_FIN2: begin
                fin_t = r_h ^ (r_h >> 13);
                n_h   = fin_t * mm3sr_pkg::C_F2;
            end
            mm3sr_pkg::H_FIN3: begin
                fin_t = r_h ^ (r_h >> 16);
                n_h   = fin_t;
            end
            default: n_h = r_h;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.k1_en) r_k1 <= r_seed[i_ctl.k1_addr] * mm3sr_pkg::C_C1;
        if (i_ctl.k2_en) r_k2 <= rot_k1 * mm3sr_pkg::C_C2;
        r_h <= n_h;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < mm3sr_pkg::SEED_WORDS; i++) r_seed[i] <= '0;
            r_run <= '0;
        end else if (i_ld_master) begin
            for (int i = 0; i < mm3sr_pkg::SEED_WORDS; i++)
                r_seed[i] <= i_master[i / 2][32 * (i % 2) +: 32];
        end else if (i_ld_derive) begin
            r_seed[0] <= r_seed[0] ^ i_block_index;
            r_run     <= i_block_index ^ mm3sr_pkg::C_RUN0;
        end else if (i_ctl.h_op == mm3sr_pkg::H_FIN3) begin
            r_seed[i_ctl.pass] <= r_seed[i_ctl.pass] ^ fin_t;
            r_run              <= fin_t;
        end
    end

    assign o_seed.seed_part_0 = {r_seed[1], r_seed[0]};
    assign o_seed.seed_part_1 = {r_seed[3], r_seed[2]};
    assign o_seed.seed_part_2 = {r_seed[5], r_seed[4]};
    assign o_seed.seed_part_3 = {r_seed[7], r_seed[6]};

endmodule

### hdl/murmur3_seed_rotator.sv
// top level of the murmur3 seed rotator: apb registers, handshakes, result register
// depends on mm3sr_pkg, mm3sr_useq, mm3sr_dpath and murmur3_seed_rotator_defines.svh
//
// Keeps a 32-byte seed. A restart item copies the four 64-bit master seed
// registers into it; a derive item XORs its block index into seed bytes 0..3
// and runs eight dependent Murmur3-32 passes, pass p folding its hash into
// seed bytes 4p..4p+3. Every item returns the whole seed as one result.
// A derive item runs a load step, eight passes of 13 microcode steps and an
// emit step; a restart item runs only the load and the emit step. Each pass
// uses the single shared mix unit, which takes one block per cycle through
// a three-deep multiply pipeline; the finalizer needs three more steps per
// pass. One item is worked on at a time; the result register lets a new item
// start while the last result waits. Registers sit at byte addresses 0, 8,
// 16, 24 and may be written only while the block is idle.
`include "murmur3_seed_rotator_defines.svh"

module murmur3_seed_rotator (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // request channel
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  mm3sr_pkg::t_req   i_req,
    // result channel
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output mm3sr_pkg::t_res   o_res,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [63:0]       pwdata,
    output logic [63:0]       prdata,
    output logic              pready
);

    mm3sr_pkg::t_master r_master;
    mm3sr_pkg::t_res    r_res;
    mm3sr_pkg::t_res    seed;
    mm3sr_pkg::t_ctl    ctl;
    logic               r_out_valid;
    logic               busy;
    logic               accept;
    logic               out_free;
    logic [1:0]         reg_idx;

    // config registers, 64 bits each at 8-byte stride
    assign pready  = 1'b1;
    assign reg_idx = paddr[4:3];
    assign prdata  = r_master[reg_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_master <= '0;
        end else if (psel && penable && pwrite && pready) begin
            r_master[reg_idx] <= pwdata;
        end
    end

    // item handshake: one item in flight at a time
    assign o_in_stall = busy;
    assign accept     = i_in_valid && !busy;

    // result register frees when empty or taken this cycle
    assign out_free = !r_out_valid || !i_out_stall;

    mm3sr_useq u_useq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (accept),
        .i_derive   (i_req.req_type == mm3sr_pkg::REQ_DERIVE),
        .i_out_free (out_free),
        .o_busy     (busy),
        .o_ctl      (ctl)
    );

    mm3sr_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ld_master   (accept && i_req.req_type == mm3sr_pkg::REQ_RESTART),
        .i_ld_derive   (accept && i_req.req_type == mm3sr_pkg::REQ_DERIVE),
        .i_block_index (i_req.block_index),
        .i_master      (r_master),
        .i_ctl         (ctl),
        .o_seed        (seed)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctl.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.emit) r_res <= seed;
    end

    assign o_out_valid = r_out_valid;
    assign o_res       = r_res;

    // an accepted item always starts the sequencer
    `MM3SR_ASSERT_NEXT(a_accept_busy, accept, busy, "sequencer idle after accepted item")
    // emitting never overwrites a result that is still held
    `MM3SR_ASSERT_SAME(a_emit_free, ctl.emit, !r_out_valid || !i_out_stall, "result overwritten")
    // emit always presents a result next cycle
    `MM3SR_ASSERT_NEXT(a_emit_valid, ctl.emit, r_out_valid, "no result after emit")

endmodule
